// File: rtl/bpvs_pkg.sv
package bpvs_pkg;

   // Fixed geometry of the bind-pose store.
   localparam int WORDS_PER_JOINT = 12;
   localparam int MATRIX_ROWS     = 4;
   localparam int MATRIX_COLS     = 3;

   // Bias is unsigned Q1.16; values above one are clamped.
   localparam int          BIAS_BITS = 16;
   localparam logic [16:0] BIAS_ONE  = 17'h10000;

   // Datapath widths.
   localparam int POS_W    = 32;
   localparam int PROD_W   = 2 * POS_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int TERM_W   = ACC_W + 1;
   localparam int SUM_W    = 48;
   localparam int MUL_W    = SUM_W + BIAS_BITS + 1;
   localparam int SCALED_W = MUL_W - BIAS_BITS;
   localparam int NEXT_W   = SCALED_W + 1;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Command codes.
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_WEIGHT = 1'b1;

   typedef struct packed {
      logic                    cmd;
      logic [5:0]              joint_index;
      logic [3:0]              word_index;
      logic signed [31:0]      word_value;
      logic [16:0]             bias;
      logic signed [31:0]      weight_x;
      logic signed [31:0]      weight_y;
      logic signed [31:0]      weight_z;
      logic                    last_weight;
   } req_type;

   typedef struct packed {
      logic signed [31:0]      pos_x;
      logic signed [31:0]      pos_y;
      logic signed [31:0]      pos_z;
      logic                    overflow;
   } rsp_type;

   // What the back part has to do with a queued item.
   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_WEIGHT = 2'd1,
      KIND_EMIT   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0] row;
      logic [1:0] col;
   } place_type;

   typedef struct packed {
      kind_type                kind;
      logic [5:0]              joint_index;
      place_type               place;
      logic signed [31:0]      word_value;
      logic [16:0]             bias;
      logic signed [31:0]      weight_x;
      logic signed [31:0]      weight_y;
      logic signed [31:0]      weight_z;
      logic                    last_weight;
   } entry_type;

   // Splits a matrix word index into its row and column.
   function automatic place_type word_place(input logic [3:0] word);
      place_type p;
      unique case (word)
         4'd0:    p = '{row: 2'd0, col: 2'd0};
         4'd1:    p = '{row: 2'd0, col: 2'd1};
         4'd2:    p = '{row: 2'd0, col: 2'd2};
         4'd3:    p = '{row: 2'd1, col: 2'd0};
         4'd4:    p = '{row: 2'd1, col: 2'd1};
         4'd5:    p = '{row: 2'd1, col: 2'd2};
         4'd6:    p = '{row: 2'd2, col: 2'd0};
         4'd7:    p = '{row: 2'd2, col: 2'd1};
         4'd8:    p = '{row: 2'd2, col: 2'd2};
         4'd9:    p = '{row: 2'd3, col: 2'd0};
         4'd10:   p = '{row: 2'd3, col: 2'd1};
         4'd11:   p = '{row: 2'd3, col: 2'd2};
         default: p = '{row: 2'd0, col: 2'd0};
      endcase
      return p;
   endfunction

endpackage

// File: rtl/bpvs_front.sv
module bpvs_front #(
   parameter int MAX_JOINTS = 64
) (
   input  logic               req_valid,
   output logic               req_ready,
   input  bpvs_pkg::req_type  req_data,
   input  logic               queue_full,
   output logic               push,
   output bpvs_pkg::entry_type push_entry
);
   import bpvs_pkg::*;

   logic        joint_ok;
   logic        word_ok;
   logic        keep;
   logic [16:0] bias_clamped;

   // Range checks and bias clamp.
   assign joint_ok     = (32'(req_data.joint_index) < MAX_JOINTS);
   assign word_ok      = (req_data.word_index < 4'(WORDS_PER_JOINT));
   assign bias_clamped = (req_data.bias > BIAS_ONE) ? BIAS_ONE : req_data.bias;

   // Classify the item; items with no effect are dropped here.
   always_comb begin
      push_entry.joint_index = req_data.joint_index;
      push_entry.place       = word_place(req_data.word_index);
      push_entry.word_value  = req_data.word_value;
      push_entry.bias        = bias_clamped;
      push_entry.weight_x    = req_data.weight_x;
      push_entry.weight_y    = req_data.weight_y;
      push_entry.weight_z    = req_data.weight_z;
      push_entry.last_weight = req_data.last_weight;
      if (req_data.cmd == CMD_WRITE) begin
         push_entry.kind = KIND_WRITE;
         keep            = joint_ok && word_ok;
      end else if ((bias_clamped != 17'd0) && joint_ok) begin
         push_entry.kind = KIND_WEIGHT;
         keep            = 1'b1;
      end else begin
         push_entry.kind = KIND_EMIT;
         keep            = req_data.last_weight;
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full && keep;

endmodule

// File: rtl/bpvs_queue.sv
module bpvs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bpvs_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output bpvs_pkg::entry_type head
);
   import bpvs_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/bpvs_back.sv
module bpvs_back #(
   parameter int MAX_JOINTS = 64,
   parameter int FRAC_BITS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  bpvs_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bpvs_pkg::rsp_type   rsp_data
);
   import bpvs_pkg::*;

   localparam int DEPTH = MAX_JOINTS * MATRIX_ROWS;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MAC   = 6'b000010,
      ST_TERM  = 6'b000100,
      ST_SCALE = 6'b001000,
      ST_ACCUM = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [2:0]             cnt_ff, cnt_in;
   entry_type              cur_ff;
   logic                   load;
   logic                   wr_en;
   logic                   emit_fire;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic [1:0]             mac_row;
   logic signed [POS_W-1:0] pos_row;

   logic signed [POS_W-1:0]  rd_ff   [MATRIX_COLS];
   logic signed [PROD_W-1:0] prod_ff [MATRIX_COLS];
   logic signed [POS_W-1:0]  m3_ff   [MATRIX_COLS];
   logic signed [ACC_W-1:0]  acc_ff  [MATRIX_COLS];
   logic signed [SUM_W-1:0]  t_ff    [MATRIX_COLS];
   logic signed [MUL_W-1:0]  mul_ff  [MATRIX_COLS];
   logic signed [SUM_W-1:0]  sum_ff  [MATRIX_COLS];
   logic signed [SUM_W-1:0]  sum_in  [MATRIX_COLS];

   logic signed [PROD_W-1:0] prod_in [MATRIX_COLS];
   logic signed [SUM_W-1:0]  t_in    [MATRIX_COLS];
   logic signed [MUL_W-1:0]  mul_in  [MATRIX_COLS];
   logic signed [SUM_W-1:0]  acc_sum [MATRIX_COLS];
   logic signed [POS_W-1:0]  out_pos [MATRIX_COLS];
   logic [MATRIX_COLS-1:0]   term_sat;
   logic [MATRIX_COLS-1:0]   sum_sat;
   logic [MATRIX_COLS-1:0]   out_sat;

   logic                     ovf_ff, ovf_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff;

   // Sequencer: one item at a time, matrix rows read one per cycle.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pop       = 1'b0;
      load      = 1'b0;
      wr_en     = 1'b0;
      emit_fire = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               pop = 1'b1;
               case (head.kind)
                  KIND_WRITE: begin
                     wr_en = 1'b1;
                  end
                  KIND_WEIGHT: begin
                     load     = 1'b1;
                     cnt_in   = 3'd0;
                     state_in = ST_MAC;
                  end
                  KIND_EMIT: begin
                     load     = 1'b1;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MAC: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            state_in = cur_ff.last_weight ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit_fire = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Store addressing: joint selects four rows, one bank per column.
   assign wr_addr = AW'({head.joint_index, head.place.row});
   assign rd_addr = AW'({cur_ff.joint_index, cnt_ff[1:0]});

   for (genvar c = 0; c < MATRIX_COLS; c++) begin : g_bank
      logic signed [POS_W-1:0] bank [DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en && (head.place.col == 2'(c))) begin
            bank[wr_addr] <= head.word_value;
         end
         rd_ff[c] <= bank[rd_addr];
      end
   end

   // Position component that matches the row now in the read register.
   assign mac_row = 2'(cnt_ff - 3'd1);

   always_comb begin
      case (mac_row)
         2'd0:    pos_row = cur_ff.weight_x;
         2'd1:    pos_row = cur_ff.weight_y;
         default: pos_row = cur_ff.weight_z;
      endcase
   end

   // Per-column arithmetic between the pipeline registers.
   always_comb begin
      logic signed [ACC_W-1:0]  shifted;
      logic signed [TERM_W-1:0] term_full;
      logic signed [SCALED_W-1:0] scaled;
      logic signed [NEXT_W-1:0] next_full;
      for (int c = 0; c < MATRIX_COLS; c++) begin
         prod_in[c] = PROD_W'(pos_row) * PROD_W'(rd_ff[c]);

         // Floor of the product sum plus the translation row, kept to 48 bits.
         shifted   = acc_ff[c] >>> FRAC_BITS;
         term_full = TERM_W'(shifted) + TERM_W'(m3_ff[c]);
         if (term_full > TERM_W'(SUM_MAX)) begin
            t_in[c]     = SUM_MAX;
            term_sat[c] = 1'b1;
         end else if (term_full < TERM_W'(SUM_MIN)) begin
            t_in[c]     = SUM_MIN;
            term_sat[c] = 1'b1;
         end else begin
            t_in[c]     = SUM_W'(term_full);
            term_sat[c] = 1'b0;
         end

         mul_in[c] = MUL_W'(t_ff[c]) * MUL_W'($signed({1'b0, cur_ff.bias}));

         // Weighted contribution added to the running sum.
         scaled    = SCALED_W'(mul_ff[c] >>> BIAS_BITS);
         next_full = NEXT_W'(sum_ff[c]) + NEXT_W'(scaled);
         if (next_full > NEXT_W'(SUM_MAX)) begin
            acc_sum[c] = SUM_MAX;
            sum_sat[c] = 1'b1;
         end else if (next_full < NEXT_W'(SUM_MIN)) begin
            acc_sum[c] = SUM_MIN;
            sum_sat[c] = 1'b1;
         end else begin
            acc_sum[c] = SUM_W'(next_full);
            sum_sat[c] = 1'b0;
         end

         // Output saturation to 32 bits.
         if (sum_ff[c] > SUM_W'(POS_MAX)) begin
            out_pos[c] = POS_MAX;
            out_sat[c] = 1'b1;
         end else if (sum_ff[c] < SUM_W'(POS_MIN)) begin
            out_pos[c] = POS_MIN;
            out_sat[c] = 1'b1;
         end else begin
            out_pos[c] = POS_W'(sum_ff[c]);
            out_sat[c] = 1'b0;
         end

         if (state_ff == ST_ACCUM) begin
            sum_in[c] = acc_sum[c];
         end else if (emit_fire) begin
            sum_in[c] = '0;
         end else begin
            sum_in[c] = sum_ff[c];
         end
      end
   end

   // Sticky overflow for the current vertex.
   always_comb begin
      ovf_in = ovf_ff;
      if (state_ff == ST_TERM) begin
         ovf_in = ovf_ff || (term_sat != '0);
      end else if (state_ff == ST_ACCUM) begin
         ovf_in = ovf_ff || (sum_sat != '0);
      end else if (emit_fire) begin
         ovf_in = 1'b0;
      end
   end

   // Result register: holds a finished vertex until the receiver takes it.
   always_comb begin
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 3'd0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < MATRIX_COLS; c++) begin
            sum_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < MATRIX_COLS; c++) begin
            sum_ff[c] <= sum_in[c];
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= head;
      end
      for (int c = 0; c < MATRIX_COLS; c++) begin
         if (state_ff == ST_MAC) begin
            if ((cnt_ff >= 3'd1) && (cnt_ff <= 3'd3)) begin
               prod_ff[c] <= prod_in[c];
            end
            if (cnt_ff == 3'd4) begin
               m3_ff[c] <= rd_ff[c];
            end
            if (cnt_ff == 3'd0) begin
               acc_ff[c] <= '0;
            end else if (cnt_ff >= 3'd2) begin
               acc_ff[c] <= acc_ff[c] + ACC_W'(prod_ff[c]);
            end
         end
         if (state_ff == ST_TERM) begin
            t_ff[c] <= t_in[c];
         end
         if (state_ff == ST_SCALE) begin
            mul_ff[c] <= mul_in[c];
         end
      end
      if (emit_fire) begin
         rsp_data_ff.pos_x    <= out_pos[0];
         rsp_data_ff.pos_y    <= out_pos[1];
         rsp_data_ff.pos_z    <= out_pos[2];
         rsp_data_ff.overflow <= ovf_ff || (out_sat != '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/bind_pose_vertex_skinning_core.sv
// Bind-pose linear blend skinning of vertex positions.
//
// Items enter on the req_ channel (valid/ready). A write item stores one
// Q16.16 word of a joint's bind-pose matrix; a weight item transforms its
// position by that joint's matrix, scales it by the bias and adds it to the
// running x, y, z sums. The last weight of a vertex sends one result item on
// the rsp_ channel: the sums saturated to 32 bits and an overflow flag.
// A front stage classifies items and drops those with no effect; a
// two-entry queue separates it from the execution unit, so req_ready only
// falls when that queue is full.
// The execution unit takes one item at a time. A matrix write is stored
// straight from the queue head; a weight passes through the MAC, TERM,
// SCALE and ACCUM states. The column-banked matrix store gives one matrix
// row per cycle, followed by the offset, bias multiply and accumulate
// steps. A last weight then goes to the EMIT state, as does a weight that
// adds nothing but ends a vertex.
// Reset clears the sums, the overflow flag, the queue and the result
// valid flag; matrix words are undefined until written. While the receiver
// stalls, the result is held and the block keeps taking items until the
// next result is ready to leave.
module bind_pose_vertex_skinning_core #(
   parameter int MAX_JOINTS = 64,
   parameter int FRAC_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bpvs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bpvs_pkg::rsp_type rsp_data
);
   import bpvs_pkg::*;

   logic      push;
   logic      pop;
   logic      queue_full;
   logic      not_empty;
   entry_type push_entry;
   entry_type head;

   bpvs_front #(
      .MAX_JOINTS (MAX_JOINTS)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   bpvs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   bpvs_back #(
      .MAX_JOINTS (MAX_JOINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
